/* design/perpendicular_offset_vectors_macros.svh */
// Assertion macros shared by the perpendicular offset vector design.
// Each macro expands to one labeled concurrent assertion clocked on clk with reset rst_n.
`ifndef PERPENDICULAR_OFFSET_VECTORS_MACROS_SVH
`define PERPENDICULAR_OFFSET_VECTORS_MACROS_SVH

// Same-cycle implication.
`define POV_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define POV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pov_pkg.sv */
// Shared constants and types for the perpendicular offset vector pipeline.
// Used by pov_sqrt, pov_div and the top level; depends on nothing.
package pov_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int UNIT_FRAC   = 30;
    localparam int MAG_W       = UNIT_FRAC + 1;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int SQRT_STAGES = SUM_W / 2;
    localparam int DIV_STAGES  = MAG_W;
    localparam int NUM_W       = MAG_W + UNIT_FRAC;
    localparam int CMP_W       = ROOT_W + MAG_W;
    localparam int GAP_W       = 31;

    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [2:0][MAG_W-1:0]     mag3_t;
    typedef logic [2:0]                sign3_t;

endpackage

/* design/pov_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on pov_pkg; the stage registers advance only while ce is high.
module pov_sqrt import pov_pkg::*;
(
    input  logic              clk,
    input  logic              ce,
    input  logic [SUM_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root
);

    logic [SUM_W-1:0] x_reg [SQRT_STAGES];
    logic [SUM_W-1:0] r_reg [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * g);
        logic [SUM_W-1:0] x_in;
        logic [SUM_W-1:0] r_in;
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] x_next;
        logic [SUM_W-1:0] r_next;

        if (g == 0) begin : g_first
            assign x_in = radicand;
            assign r_in = '0;
        end
        else begin : g_rest
            assign x_in = x_reg[g-1];
            assign r_in = r_reg[g-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (x_in >= trial)
            begin
                x_next = x_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                x_reg[g] <= x_next;
                r_reg[g] <= r_next;
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

/* design/pov_div.sv */
// Pipelined restoring divider for three lanes sharing one divisor: (num << 30) / den.
// Depends on pov_pkg; one quotient bit per stage.
module pov_div import pov_pkg::*;
(
    input  logic              clk,
    input  logic              ce,
    input  mag3_t             num,
    input  logic [ROOT_W-1:0] den,
    output mag3_t             quot
);

    logic [NUM_W-1:0]  rem_reg [DIV_STAGES][3];
    mag3_t             q_reg   [DIV_STAGES];
    logic [ROOT_W-1:0] den_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        localparam int SH = MAG_W - 1 - g;
        logic [NUM_W-1:0]  rem_in  [3];
        mag3_t             q_in;
        logic [ROOT_W-1:0] den_in;
        logic [CMP_W-1:0]  dsh;
        logic [NUM_W-1:0]  rem_next [3];
        mag3_t             q_next;

        if (g == 0) begin : g_first
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = {num[l], {UNIT_FRAC{1'b0}}};
            end
            assign q_in   = '0;
            assign den_in = den;
        end
        else begin : g_rest
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = rem_reg[g-1][l];
            end
            assign q_in   = q_reg[g-1];
            assign den_in = den_reg[g-1];
        end

        always_comb
        begin
            dsh = CMP_W'(den_in) << SH;
            q_next = q_in;
            for (int l = 0; l < 3; l++)
            begin
                if (CMP_W'(rem_in[l]) >= dsh)
                begin
                    rem_next[l] = rem_in[l] - NUM_W'(dsh);
                    q_next[l]   = q_in[l] | (MAG_W'(1) << SH);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[g][l] <= rem_next[l];
                end
                q_reg[g]   <= q_next;
                den_reg[g] <= den_in;
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule

/* design/perpendicular_offset_vectors.sv */
// Top level of the perpendicular offset vector pipeline.
// Depends on pov_pkg, pov_sqrt, pov_div and perpendicular_offset_vectors_macros.svh.
//
// Each input word carries a segment's start and end points; the block returns two vectors
// perpendicular to the segment and to each other, each as long as the gap register, with the
// degenerate flag set for a zero-length segment. One word is accepted every clock cycle while
// s_axis_tready is high; the path runs through the two 32-stage square-root units and the two
// 31-stage dividers. The pipeline holds only while its output skid
// register is full. The gap register may be written only while the pipeline is empty.
`include "perpendicular_offset_vectors_macros.svh"

module perpendicular_offset_vectors import pov_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [GAP_W-1:0]         cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [6*COORD_WIDTH-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    output logic [6*COORD_WIDTH-1:0] m_axis_tdata,
    // degenerate
    output logic                     m_axis_tuser
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int TOP_W  = $clog2(DW);
    localparam int SH_W   = DW + MAG_W;
    localparam int V_W    = MAG_W + 2;
    localparam int S_W    = MAG_W + 1;
    localparam int SC_W   = S_W + GAP_W;
    localparam int SAT_W  = (CW >= 33) ? CW + 1 : 34;
    localparam logic [SQ_W-1:0] HALF_SQ = SQ_W'(1) << (UNIT_FRAC - 1);
    localparam logic [SC_W-1:0] HALF_SC = SC_W'(1) << (UNIT_FRAC - 1);
    localparam logic [V_W-1:0]  ONE_V   = V_W'(1) << UNIT_FRAC;

    typedef struct packed {
        logic   degen;
        sign3_t neg;
        mag3_t  mag;
    } side1_t;

    typedef struct packed {
        logic   degen;
        sign3_t neg;
    } side2_t;

    typedef struct packed {
        logic   degen;
        sign3_t vneg;
        mag3_t  vmag;
        sign3_t uneg;
        mag3_t  umag;
    } side3_t;

    typedef struct packed {
        logic   degen;
        logic   zero_len;
        sign3_t vneg;
        sign3_t uneg;
        mag3_t  umag;
    } side4_t;

    logic ce;
    logic [GAP_W-1:0] gap_reg;

    // Stage valid bits.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic [SQRT_STAGES-1:0] sq1_vld_reg;
    logic [DIV_STAGES-1:0]  dv1_vld_reg;
    logic e1_vld_reg, e2_vld_reg, e3_vld_reg, e4_vld_reg, e5_vld_reg;
    logic [SQRT_STAGES-1:0] sq2_vld_reg;
    logic [DIV_STAGES-1:0]  dv2_vld_reg;
    logic f_vld_reg, g1_vld_reg, g2_vld_reg, g3_vld_reg, g4_vld_reg;
    logic out_vld_reg, skid_vld_reg;

    // Stage payloads.
    logic [2:0][DW-1:0]  s1_mag_reg, s2_mag_reg;
    sign3_t              s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg;
    logic [TOP_W-1:0]    s2_top_reg;
    logic                s2_degen_reg, s3_degen_reg, s4_degen_reg, s5_degen_reg;
    mag3_t               s3_mag_reg, s4_mag_reg, s5_mag_reg;
    logic [2:0][SQ_W-1:0] s4_sq_reg;
    logic [SUM_W-1:0]    s5_sum_reg;
    side1_t              sq1_side_reg [SQRT_STAGES];
    side2_t              dv1_side_reg [DIV_STAGES];
    mag3_t               e1_umag_reg, e2_umag_reg, e3_umag_reg, e4_umag_reg, e5_umag_reg;
    sign3_t              e1_uneg_reg, e2_uneg_reg, e3_uneg_reg, e4_uneg_reg, e5_uneg_reg;
    logic [1:0]          e1_k_reg, e2_k_reg;
    logic                e1_degen_reg, e2_degen_reg, e3_degen_reg, e4_degen_reg, e5_degen_reg;
    logic [2:0][SQ_W-1:0] e2_p_reg;
    sign3_t              e2_pneg_reg;
    mag3_t               e3_vmag_reg, e4_vmag_reg, e5_vmag_reg;
    sign3_t              e3_vneg_reg, e4_vneg_reg, e5_vneg_reg;
    logic [2:0][SQ_W-1:0] e4_sq_reg;
    logic [SUM_W-1:0]    e5_sum_reg;
    side3_t              sq2_side_reg [SQRT_STAGES];
    side4_t              dv2_side_reg [DIV_STAGES];
    mag3_t               f_fmag_reg, g1_fmag_reg, g2_fmag_reg;
    sign3_t              f_fneg_reg, g1_fneg_reg, g2_fneg_reg;
    mag3_t               f_umag_reg;
    sign3_t              f_uneg_reg;
    logic                f_degen_reg, g1_degen_reg, g2_degen_reg, g3_degen_reg, g4_degen_reg;
    logic [5:0][SQ_W-1:0] g1_p_reg;
    logic [5:0]          g1_pneg_reg;
    logic [2:0][S_W-1:0] g2_smag_reg;
    sign3_t              g2_sneg_reg;
    logic [5:0][SC_W-1:0] g3_p_reg;
    logic [5:0]          g3_neg_reg;
    logic [6*CW-1:0]     g4_data_reg, out_data_reg, skid_data_reg;
    logic                out_degen_reg, skid_degen_reg;

    // Combinational stage results.
    logic [2:0][DW-1:0]  d_mag;
    sign3_t              d_neg;
    logic [DW-1:0]       mx;
    logic [TOP_W-1:0]    top;
    mag3_t               n_mag;
    logic [ROOT_W-1:0]   root1, root2;
    mag3_t               q1, q2;
    logic [1:0]          k_sel;
    mag3_t               v_mag;
    sign3_t              v_neg;
    logic [5:0][SQ_W-1:0] cp;
    logic [5:0]          cp_neg;
    logic [2:0][S_W-1:0] s_mag;
    sign3_t              s_neg;
    logic [6*CW-1:0]     sat_data;

    assign ce            = !skid_vld_reg;
    assign s_axis_tready = ce;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GAP_W'(65536);
        end
        else if (cfg_valid)
        begin
            gap_reg <= cfg_data;
        end
    end

    // Direction and its magnitudes.
    always_comb
    begin
        logic [CW-1:0] st;
        logic [CW-1:0] en;
        logic [DW:0]   diff;
        for (int i = 0; i < 3; i++)
        begin
            st = s_axis_tdata[i*CW +: CW];
            en = s_axis_tdata[(i+3)*CW +: CW];
            diff = {{2{en[CW-1]}}, en} - {{2{st[CW-1]}}, st};
            d_neg[i] = diff[DW];
            d_mag[i] = diff[DW] ? DW'(-diff) : diff[DW-1:0];
        end
    end

    // Largest magnitude and its leading one.
    always_comb
    begin
        mx = s1_mag_reg[0];
        if (s1_mag_reg[1] > mx)
        begin
            mx = s1_mag_reg[1];
        end
        if (s1_mag_reg[2] > mx)
        begin
            mx = s1_mag_reg[2];
        end
        top = '0;
        for (int b = 0; b < DW; b++)
        begin
            if (mx[b])
            begin
                top = TOP_W'(b);
            end
        end
    end

    // Common shift that brings the largest magnitude into [2^30, 2^31).
    always_comb
    begin
        logic [SH_W-1:0] ext;
        logic [SH_W-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            ext = SH_W'(s2_mag_reg[i]);
            if (int'(s2_top_reg) > UNIT_FRAC)
            begin
                sh = ext >> (int'(s2_top_reg) - UNIT_FRAC);
            end
            else
            begin
                sh = ext << (UNIT_FRAC - int'(s2_top_reg));
            end
            n_mag[i] = sh[MAG_W-1:0];
        end
    end

    pov_sqrt u_sqrt1
    (
        .clk      (clk),
        .ce       (ce),
        .radicand (s5_sum_reg),
        .root     (root1)
    );

    pov_div u_div1
    (
        .clk  (clk),
        .ce   (ce),
        .num  (sq1_side_reg[SQRT_STAGES-1].mag),
        .den  (root1),
        .quot (q1)
    );

    // Axis with the smallest unit component, lowest index on ties.
    always_comb
    begin
        k_sel = 2'd0;
        if (q1[1] < q1[0])
        begin
            k_sel = 2'd1;
        end
        if (q1[2] < q1[k_sel])
        begin
            k_sel = 2'd2;
        end
    end

    // Remainder e_k - u_k * u.
    always_comb
    begin
        logic [SQ_W-1:0] rnd;
        logic [V_W-1:0]  qv;
        logic [V_W-1:0]  base;
        logic [V_W-1:0]  v;
        for (int i = 0; i < 3; i++)
        begin
            rnd = (e2_p_reg[i] + HALF_SQ) >> UNIT_FRAC;
            qv = e2_pneg_reg[i] ? -V_W'(rnd) : V_W'(rnd);
            base = (e2_k_reg == 2'(i)) ? ONE_V : '0;
            v = base - qv;
            v_neg[i] = v[V_W-1];
            v_mag[i] = v[V_W-1] ? MAG_W'(-v) : v[MAG_W-1:0];
        end
    end

    pov_sqrt u_sqrt2
    (
        .clk      (clk),
        .ce       (ce),
        .radicand (e5_sum_reg),
        .root     (root2)
    );

    pov_div u_div2
    (
        .clk  (clk),
        .ce   (ce),
        .num  (sq2_side_reg[SQRT_STAGES-1].vmag),
        .den  (root2),
        .quot (q2)
    );

    // Cross product terms u1f2, u2f1, u2f0, u0f2, u0f1, u1f0.
    always_comb
    begin
        cp[0] = SQ_W'(f_umag_reg[1]) * SQ_W'(f_fmag_reg[2]);
        cp[1] = SQ_W'(f_umag_reg[2]) * SQ_W'(f_fmag_reg[1]);
        cp[2] = SQ_W'(f_umag_reg[2]) * SQ_W'(f_fmag_reg[0]);
        cp[3] = SQ_W'(f_umag_reg[0]) * SQ_W'(f_fmag_reg[2]);
        cp[4] = SQ_W'(f_umag_reg[0]) * SQ_W'(f_fmag_reg[1]);
        cp[5] = SQ_W'(f_umag_reg[1]) * SQ_W'(f_fmag_reg[0]);
        cp_neg[0] = f_uneg_reg[1] ^ f_fneg_reg[2];
        cp_neg[1] = f_uneg_reg[2] ^ f_fneg_reg[1];
        cp_neg[2] = f_uneg_reg[2] ^ f_fneg_reg[0];
        cp_neg[3] = f_uneg_reg[0] ^ f_fneg_reg[2];
        cp_neg[4] = f_uneg_reg[0] ^ f_fneg_reg[1];
        cp_neg[5] = f_uneg_reg[1] ^ f_fneg_reg[0];
    end

    always_comb
    begin
        logic [SQ_W-1:0] rnd;
        logic [V_W-1:0]  t [6];
        logic [V_W-1:0]  s;
        for (int j = 0; j < 6; j++)
        begin
            rnd = (g1_p_reg[j] + HALF_SQ) >> UNIT_FRAC;
            t[j] = g1_pneg_reg[j] ? -V_W'(rnd) : V_W'(rnd);
        end
        for (int i = 0; i < 3; i++)
        begin
            s = t[2*i] - t[2*i+1];
            s_neg[i] = s[V_W-1];
            s_mag[i] = s[V_W-1] ? S_W'(-s) : s[S_W-1:0];
        end
    end

    // Round, restore sign and saturate to the coordinate range.
    always_comb
    begin
        logic [SC_W-1:0]  rnd;
        logic [SAT_W-1:0] m;
        logic [SAT_W-1:0] lim;
        logic [SAT_W-1:0] r;
        for (int j = 0; j < 6; j++)
        begin
            rnd = (g3_p_reg[j] + HALF_SC) >> UNIT_FRAC;
            m = SAT_W'(rnd);
            lim = g3_neg_reg[j] ? (SAT_W'(1) << (CW - 1)) : ((SAT_W'(1) << (CW - 1)) - 1'b1);
            if (m > lim)
            begin
                m = lim;
            end
            r = g3_neg_reg[j] ? -m : m;
            sat_data[j*CW +: CW] = g3_degen_reg ? '0 : r[CW-1:0];
        end
    end

    // Valid bits travel with each word through the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            sq1_vld_reg <= '0;
            dv1_vld_reg <= '0;
            e1_vld_reg  <= 1'b0;
            e2_vld_reg  <= 1'b0;
            e3_vld_reg  <= 1'b0;
            e4_vld_reg  <= 1'b0;
            e5_vld_reg  <= 1'b0;
            sq2_vld_reg <= '0;
            dv2_vld_reg <= '0;
            f_vld_reg   <= 1'b0;
            g1_vld_reg  <= 1'b0;
            g2_vld_reg  <= 1'b0;
            g3_vld_reg  <= 1'b0;
            g4_vld_reg  <= 1'b0;
        end
        else if (ce)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            sq1_vld_reg <= {sq1_vld_reg[SQRT_STAGES-2:0], s5_vld_reg};
            dv1_vld_reg <= {dv1_vld_reg[DIV_STAGES-2:0], sq1_vld_reg[SQRT_STAGES-1]};
            e1_vld_reg  <= dv1_vld_reg[DIV_STAGES-1];
            e2_vld_reg  <= e1_vld_reg;
            e3_vld_reg  <= e2_vld_reg;
            e4_vld_reg  <= e3_vld_reg;
            e5_vld_reg  <= e4_vld_reg;
            sq2_vld_reg <= {sq2_vld_reg[SQRT_STAGES-2:0], e5_vld_reg};
            dv2_vld_reg <= {dv2_vld_reg[DIV_STAGES-2:0], sq2_vld_reg[SQRT_STAGES-1]};
            f_vld_reg   <= dv2_vld_reg[DIV_STAGES-1];
            g1_vld_reg  <= f_vld_reg;
            g2_vld_reg  <= g1_vld_reg;
            g3_vld_reg  <= g2_vld_reg;
            g4_vld_reg  <= g3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_mag_reg   <= d_mag;
            s1_neg_reg   <= d_neg;

            s2_mag_reg   <= s1_mag_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_top_reg   <= top;
            s2_degen_reg <= (mx == '0);

            s3_mag_reg   <= n_mag;
            s3_neg_reg   <= s2_neg_reg;
            s3_degen_reg <= s2_degen_reg;

            for (int i = 0; i < 3; i++)
            begin
                s4_sq_reg[i] <= SQ_W'(s3_mag_reg[i]) * SQ_W'(s3_mag_reg[i]);
            end
            s4_mag_reg   <= s3_mag_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_degen_reg <= s3_degen_reg;

            s5_sum_reg   <= SUM_W'(s4_sq_reg[0]) + SUM_W'(s4_sq_reg[1]) + SUM_W'(s4_sq_reg[2]);
            s5_mag_reg   <= s4_mag_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_degen_reg <= s4_degen_reg;

            sq1_side_reg[0] <= '{degen: s5_degen_reg, neg: s5_neg_reg, mag: s5_mag_reg};
            for (int i = 1; i < SQRT_STAGES; i++)
            begin
                sq1_side_reg[i] <= sq1_side_reg[i-1];
            end

            dv1_side_reg[0] <= '{degen: sq1_side_reg[SQRT_STAGES-1].degen,
                                 neg:   sq1_side_reg[SQRT_STAGES-1].neg};
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv1_side_reg[i] <= dv1_side_reg[i-1];
            end

            e1_umag_reg  <= q1;
            e1_uneg_reg  <= dv1_side_reg[DIV_STAGES-1].neg;
            e1_k_reg     <= k_sel;
            e1_degen_reg <= dv1_side_reg[DIV_STAGES-1].degen;

            for (int i = 0; i < 3; i++)
            begin
                e2_p_reg[i]    <= SQ_W'(e1_umag_reg[e1_k_reg]) * SQ_W'(e1_umag_reg[i]);
                e2_pneg_reg[i] <= e1_uneg_reg[e1_k_reg] ^ e1_uneg_reg[i];
            end
            e2_k_reg     <= e1_k_reg;
            e2_umag_reg  <= e1_umag_reg;
            e2_uneg_reg  <= e1_uneg_reg;
            e2_degen_reg <= e1_degen_reg;

            e3_vmag_reg  <= v_mag;
            e3_vneg_reg  <= v_neg;
            e3_umag_reg  <= e2_umag_reg;
            e3_uneg_reg  <= e2_uneg_reg;
            e3_degen_reg <= e2_degen_reg;

            for (int i = 0; i < 3; i++)
            begin
                e4_sq_reg[i] <= SQ_W'(e3_vmag_reg[i]) * SQ_W'(e3_vmag_reg[i]);
            end
            e4_vmag_reg  <= e3_vmag_reg;
            e4_vneg_reg  <= e3_vneg_reg;
            e4_umag_reg  <= e3_umag_reg;
            e4_uneg_reg  <= e3_uneg_reg;
            e4_degen_reg <= e3_degen_reg;

            e5_sum_reg   <= SUM_W'(e4_sq_reg[0]) + SUM_W'(e4_sq_reg[1]) + SUM_W'(e4_sq_reg[2]);
            e5_vmag_reg  <= e4_vmag_reg;
            e5_vneg_reg  <= e4_vneg_reg;
            e5_umag_reg  <= e4_umag_reg;
            e5_uneg_reg  <= e4_uneg_reg;
            e5_degen_reg <= e4_degen_reg;

            sq2_side_reg[0] <= '{degen: e5_degen_reg, vneg: e5_vneg_reg, vmag: e5_vmag_reg,
                                 uneg: e5_uneg_reg, umag: e5_umag_reg};
            for (int i = 1; i < SQRT_STAGES; i++)
            begin
                sq2_side_reg[i] <= sq2_side_reg[i-1];
            end

            dv2_side_reg[0] <= '{degen:    sq2_side_reg[SQRT_STAGES-1].degen,
                                 zero_len: (root2 == '0),
                                 vneg:     sq2_side_reg[SQRT_STAGES-1].vneg,
                                 uneg:     sq2_side_reg[SQRT_STAGES-1].uneg,
                                 umag:     sq2_side_reg[SQRT_STAGES-1].umag};
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv2_side_reg[i] <= dv2_side_reg[i-1];
            end

            f_fmag_reg  <= dv2_side_reg[DIV_STAGES-1].zero_len ? '0 : q2;
            f_fneg_reg  <= dv2_side_reg[DIV_STAGES-1].vneg;
            f_umag_reg  <= dv2_side_reg[DIV_STAGES-1].umag;
            f_uneg_reg  <= dv2_side_reg[DIV_STAGES-1].uneg;
            f_degen_reg <= dv2_side_reg[DIV_STAGES-1].degen;

            g1_p_reg     <= cp;
            g1_pneg_reg  <= cp_neg;
            g1_fmag_reg  <= f_fmag_reg;
            g1_fneg_reg  <= f_fneg_reg;
            g1_degen_reg <= f_degen_reg;

            g2_smag_reg  <= s_mag;
            g2_sneg_reg  <= s_neg;
            g2_fmag_reg  <= g1_fmag_reg;
            g2_fneg_reg  <= g1_fneg_reg;
            g2_degen_reg <= g1_degen_reg;

            for (int i = 0; i < 3; i++)
            begin
                g3_p_reg[i]     <= SC_W'(g2_fmag_reg[i]) * SC_W'(gap_reg);
                g3_neg_reg[i]   <= g2_fneg_reg[i];
                g3_p_reg[i+3]   <= SC_W'(g2_smag_reg[i]) * SC_W'(gap_reg);
                g3_neg_reg[i+3] <= g2_sneg_reg[i];
            end
            g3_degen_reg <= g2_degen_reg;

            g4_data_reg  <= sat_data;
            g4_degen_reg <= g3_degen_reg;
        end
    end

    // Output register with one skid word behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (m_axis_tready)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (g4_vld_reg)
        begin
            if (!out_vld_reg || m_axis_tready)
            begin
                out_vld_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_reg  <= skid_data_reg;
                out_degen_reg <= skid_degen_reg;
            end
        end
        else if (g4_vld_reg)
        begin
            if (!out_vld_reg || m_axis_tready)
            begin
                out_data_reg  <= g4_data_reg;
                out_degen_reg <= g4_degen_reg;
            end
            else
            begin
                skid_data_reg  <= g4_data_reg;
                skid_degen_reg <= g4_degen_reg;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_degen_reg;

    `POV_ASSERT_IMPLIES(a_skid_behind_out, skid_vld_reg, out_vld_reg,
        "skid word held while the output register is empty")
    `POV_ASSERT_IMPLIES(a_degen_zero, out_vld_reg && out_degen_reg, out_data_reg == '0,
        "degenerate word carries nonzero vectors")
    `POV_ASSERT_NEXT(a_stall_holds, !ce, g4_vld_reg == $past(g4_vld_reg),
        "last pipeline stage changed during a stall")

endmodule
